// ----- sv/hrhs_pkg.sv -----
// Shared constants, types and helper functions for the HTTP response header scanner.
package hrhs_pkg;

  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChBlank = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChTwo   = 8'h32;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5a;
  localparam logic [7:0] CaseGap = 8'h20;

  localparam int unsigned LenW     = 32;
  localparam int unsigned PosW     = 4;
  localparam logic [PosW-1:0] TitleLen = 4'd15;
  localparam logic [LenW-1:0] LenAllOnes = 32'hffff_ffff;

  typedef struct packed {
    logic            header_complete;
    logic            in_body;
    logic            response_ok;
    logic [LenW-1:0] body_length;
  } hrhs_result_t;

  // Characters of the lower-case "content-length:" title, by position.
  function automatic logic [7:0] title_char(input logic [PosW-1:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h63; // c
      4'd1:    c = 8'h6f; // o
      4'd2:    c = 8'h6e; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6e; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2d; // -
      4'd8:    c = 8'h6c; // l
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6e; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      4'd14:   c = 8'h3a; // :
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= ChUpA && c <= ChUpZ) begin
      r = c + CaseGap;
    end
    return r;
  endfunction

endpackage

// ----- sv/hrhs_scan_core.sv -----
// Scanner state registers and the per-byte next-state and result logic.
module hrhs_scan_core
  import hrhs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         fire_i,
  input  logic [7:0]   data_byte_i,
  input  logic         new_response_i,
  output hrhs_result_t result_o
);

  logic [7:0]      rb0_q, rb1_q, rb2_q, rb0_d, rb1_d, rb2_d;
  logic            begun_q, begun_d;
  logic            finished_q, finished_d;
  logic            ok_q, ok_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            lsd_q, lsd_d;
  logic [LenW-1:0] len_q, len_d;

  logic [LenW+3:0] len_mul;
  logic            is_digit;

  always_comb begin
    logic [7:0]      c0, c1, c2;
    logic            cbegun, cfin, cok, clsd;
    logic [PosW-1:0] cpos;
    logic [LenW-1:0] clen;
    logic            done, body;

    // clear first on a new response, then scan the byte
    c0     = new_response_i ? 8'h00 : rb0_q;
    c1     = new_response_i ? 8'h00 : rb1_q;
    c2     = new_response_i ? 8'h00 : rb2_q;
    cbegun = new_response_i ? 1'b0 : begun_q;
    cfin   = new_response_i ? 1'b0 : finished_q;
    cok    = new_response_i ? 1'b0 : ok_q;
    cpos   = new_response_i ? '0 : pos_q;
    clsd   = new_response_i ? 1'b0 : lsd_q;
    clen   = new_response_i ? LenAllOnes : len_q;

    rb0_d      = c0;
    rb1_d      = c1;
    rb2_d      = c2;
    begun_d    = cbegun;
    finished_d = cfin;
    ok_d       = cok;
    pos_d      = cpos;
    lsd_d      = clsd;
    len_d      = clen;
    done       = 1'b0;
    body       = 1'b0;

    is_digit = (data_byte_i >= ChZero) && (data_byte_i <= ChNine);
    len_mul  = {4'b0, clen} * 36'd10 + {28'b0, data_byte_i - ChZero};

    if (cfin) begin
      body = 1'b1;
    end else begin
      if (data_byte_i != ChBlank && data_byte_i != ChCr && data_byte_i != ChLf) begin
        begun_d = 1'b1;
      end
      if (c2 == ChCr && c1 == ChLf && c0 == ChCr && data_byte_i == ChLf && begun_d) begin
        finished_d = 1'b1;
        done       = 1'b1;
      end else begin
        if (c2 == ChBlank && c1 == ChTwo && c0 == ChZero && data_byte_i == ChZero) begin
          ok_d = 1'b1;
        end
        if (!clsd) begin
          if (cpos == TitleLen) begin
            if (data_byte_i != ChBlank) begin
              if (!is_digit) begin
                lsd_d = 1'b1;
              end else if (len_mul[LenW+3:LenW] != '0) begin
                len_d = LenAllOnes;
              end else begin
                len_d = len_mul[LenW-1:0];
              end
            end
          end else if (to_lower(data_byte_i) == title_char(cpos)) begin
            pos_d = cpos + 1'b1;
            if (pos_d == TitleLen) begin
              len_d = '0;
            end
          end else begin
            pos_d = '0;
          end
        end
        rb2_d = c1;
        rb1_d = c0;
        rb0_d = data_byte_i;
      end
    end

    result_o.header_complete = done;
    result_o.in_body         = body;
    result_o.response_ok     = ok_d;
    result_o.body_length     = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rb0_q      <= '0;
      rb1_q      <= '0;
      rb2_q      <= '0;
      begun_q    <= 1'b0;
      finished_q <= 1'b0;
      ok_q       <= 1'b0;
      pos_q      <= '0;
      lsd_q      <= 1'b0;
      len_q      <= LenAllOnes;
    end else if (fire_i) begin
      rb0_q      <= rb0_d;
      rb1_q      <= rb1_d;
      rb2_q      <= rb2_d;
      begun_q    <= begun_d;
      finished_q <= finished_d;
      ok_q       <= ok_d;
      pos_q      <= pos_d;
      lsd_q      <= lsd_d;
      len_q      <= len_d;
    end
  end

`ifndef SYNTHESIS
  a_fin_needs_begun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |-> begun_q)
    else $error("header finished without header start");
  a_lsd_needs_title: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lsd_q |-> (pos_q == TitleLen))
    else $error("length scan ended before title match");
  a_pos_needs_begun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q != '0) |-> begun_q)
    else $error("title progress without header start");
`endif

endmodule

// ----- sv/http_response_header_scanner_unit.sv -----
// Top level: input register, scan core and result register of the header scanner.
//
// Scans an HTTP response one byte per item and returns one result per byte:
// header end flag, body flag, 200-OK flag and parsed length value (all ones
// when not given). A byte is taken into an input register, scanned against the
// held state once the result register is free or being emptied, and written to
// a result register; while the output does not stall, one byte per cycle is
// sustained. The rate is set by the state update loop in the scan core, whose
// next state is formed combinationally from the held state and the byte. While a
// result waits to be taken, one more byte is held in the input register and the
// input then stalls; set new_response_i on the first byte of each response.
module http_response_header_scanner_unit
  import hrhs_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      data_byte_i,
  input  logic            new_response_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            header_complete_o,
  output logic            in_body_o,
  output logic            response_ok_o,
  output logic [LenW-1:0] body_length_o
);

  logic         in_valid_q, in_valid_d;
  logic [7:0]   data_q;
  logic         new_q;
  logic         out_valid_q, out_valid_d;
  hrhs_result_t res_q;
  hrhs_result_t core_res;
  logic         fire;
  logic         accept;

  // scan the held item when the result register is free or being emptied
  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  assign in_valid_d  = accept | (in_valid_q & ~fire);
  assign out_valid_d = fire | (out_valid_q & out_stall_i);

  hrhs_scan_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .data_byte_i    (data_q),
    .new_response_i (new_q),
    .result_o       (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_byte_i;
      new_q  <= new_response_i;
    end
    if (fire) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign header_complete_o = res_q.header_complete;
  assign in_body_o         = res_q.in_body;
  assign response_ok_o     = res_q.response_ok;
  assign body_length_o     = res_q.body_length;

`ifndef SYNTHESIS
  a_fire_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("scanned item lost before result register");
  a_held_item_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !fire) |=> (in_valid_q && $stable(data_q)))
    else $error("held input item dropped or changed");
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.header_complete && res_q.in_body))
    else $error("header end and body flagged on the same item");
`endif

endmodule
